// ===== rtl/krt_pkg.sv =====
package krt_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  // One stored record.
  typedef struct packed {
    logic        [31:0] key;
    logic signed [31:0] quantity;
    logic        [31:0] price_cents;
  } rec_t;

endpackage

// ===== rtl/krt_if.sv =====
interface krt_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [31:0] record_key;
  logic signed [31:0] new_quantity;
  logic        [31:0] new_price_cents;

  modport source (output valid, action, record_key, new_quantity, new_price_cents,
                  input ready);
  modport sink   (input valid, action, record_key, new_quantity, new_price_cents,
                  output ready);
endinterface

interface krt_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] found_quantity;
  logic        [31:0] found_price_cents;
  logic        [7:0]  record_count;

  modport source (output valid, status, found_quantity, found_price_cents, record_count,
                  input ready);
  modport sink   (input valid, status, found_quantity, found_price_cents, record_count,
                  output ready);
endinterface

// ===== rtl/krt_store.sv =====
module krt_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  krt_pkg::rec_t  wr_rec,
  input  logic [AW-1:0]  rd_addr,
  output krt_pkg::rec_t  rd_rec
);

  // Single write port, single registered read port.
  krt_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    rd_rec <= mem[rd_addr];
  end

endmodule

// ===== rtl/keyed_record_table.sv =====
// Channel | Dir | Signals                       | Accepted when
// in_ch   | in  | action, key, quantity, price  | in_ch.valid && in_ch.ready
// out_ch  | out | status, quantity, price, count| out_ch.valid && out_ch.ready
//
// Operation: an add, unless the table is full, writes its record when it is
// accepted and goes straight to the result. A search, update or delete walks
// the record memory one entry per cycle until the first match; a delete then
// moves each later record down by one entry. Compares and moves together never
// exceed the count, and the pace of the walk is set by the single read port of
// the record memory.
// Reset: rst_n is synchronous and active low; it empties the table.
// Stalls: in_ch.ready is high only while idle; a result holds until taken.
module keyed_record_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic   clk,
  input  logic   rst_n,
  krt_in_if.sink    in_ch,
  krt_out_if.source out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = CW + 1;

  // Sequencer state and the latched request.
  krt_pkg::state_t    state_r, state_nxt;
  krt_pkg::action_t   act_r, act_nxt;
  logic        [31:0] key_r, key_nxt;
  logic signed [31:0] qty_r, qty_nxt;
  logic        [31:0] price_r, price_nxt;

  // Walk index and record count.
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Result register, shown on out_ch while in the result state.
  krt_pkg::status_t   status_r, status_nxt;
  logic signed [31:0] fq_r, fq_nxt;
  logic        [31:0] fp_r, fp_nxt;

  // Record memory port.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  krt_pkg::rec_t wr_rec;
  logic [AW-1:0] rd_addr;
  krt_pkg::rec_t rd_rec;

  logic             accept;
  krt_pkg::action_t in_act;
  logic [EW-1:0]    idx_ext;
  logic [EW-1:0]    cnt_ext;
  logic             hit;
  logic             next_valid;
  logic             shift_more;
  logic             full;
  logic             empty;

  krt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec)
  );

  assign in_ch.ready  = (state_r == krt_pkg::ST_IDLE);
  assign out_ch.valid = (state_r == krt_pkg::ST_RESP);
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_act       = krt_pkg::action_t'(in_ch.action);

  // The shared compare unit: one key compare and the index bounds checks.
  assign idx_ext    = EW'(idx_r);
  assign cnt_ext    = EW'(count_r);
  assign hit        = (rd_rec.key == key_r);
  assign next_valid = (idx_ext + EW'(1)) < cnt_ext;
  assign shift_more = (idx_ext + EW'(2)) < cnt_ext;
  assign full       = (count_r == CW'(TABLE_DEPTH));
  assign empty      = (count_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      krt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_act == krt_pkg::ACT_ADD || empty) begin
            state_nxt = krt_pkg::ST_RESP;
          end else begin
            state_nxt = krt_pkg::ST_SCAN;
          end
        end
      end
      krt_pkg::ST_SCAN: begin
        if (hit) begin
          if (act_r == krt_pkg::ACT_DELETE && next_valid) begin
            state_nxt = krt_pkg::ST_SHIFT;
          end else begin
            state_nxt = krt_pkg::ST_RESP;
          end
        end else if (!next_valid) begin
          state_nxt = krt_pkg::ST_RESP;
        end
      end
      krt_pkg::ST_SHIFT: begin
        if (!shift_more) begin
          state_nxt = krt_pkg::ST_RESP;
        end
      end
      krt_pkg::ST_RESP: begin
        if (out_ch.ready) begin
          state_nxt = krt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = krt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory port control.
  always_comb begin
    act_nxt    = act_r;
    key_nxt    = key_r;
    qty_nxt    = qty_r;
    price_nxt  = price_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    fq_nxt     = fq_r;
    fp_nxt     = fp_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_rec     = rd_rec;
    rd_addr    = '0;
    unique case (state_r)
      krt_pkg::ST_IDLE: begin
        // Entry zero is read now so the walk can compare it next cycle.
        if (accept) begin
          act_nxt    = in_act;
          key_nxt    = in_ch.record_key;
          qty_nxt    = in_ch.new_quantity;
          price_nxt  = in_ch.new_price_cents;
          idx_nxt    = '0;
          status_nxt = krt_pkg::STAT_DONE;
          fq_nxt     = '0;
          fp_nxt     = '0;
          if (in_act == krt_pkg::ACT_ADD) begin
            if (full) begin
              status_nxt = krt_pkg::STAT_FULL;
            end else begin
              wr_en              = 1'b1;
              wr_addr            = count_r[AW-1:0];
              wr_rec.key         = in_ch.record_key;
              wr_rec.quantity    = in_ch.new_quantity;
              wr_rec.price_cents = in_ch.new_price_cents;
              count_nxt          = count_r + CW'(1);
            end
          end else if (empty) begin
            status_nxt = krt_pkg::STAT_MISSING;
          end
        end
      end
      krt_pkg::ST_SCAN: begin
        // rd_rec holds the entry at idx_r.
        if (hit) begin
          case (act_r)
            krt_pkg::ACT_SEARCH: begin
              fq_nxt = rd_rec.quantity;
              fp_nxt = rd_rec.price_cents;
            end
            krt_pkg::ACT_UPDATE: begin
              wr_en              = 1'b1;
              wr_rec.quantity    = qty_r;
              wr_rec.price_cents = price_r;
            end
            krt_pkg::ACT_DELETE: begin
              if (next_valid) begin
                rd_addr = AW'(idx_ext + EW'(1));
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: ;
          endcase
        end else if (next_valid) begin
          rd_addr = AW'(idx_ext + EW'(1));
          idx_nxt = AW'(idx_ext + EW'(1));
        end else begin
          status_nxt = krt_pkg::STAT_MISSING;
        end
      end
      krt_pkg::ST_SHIFT: begin
        // rd_rec holds the entry above idx_r; it moves down into idx_r.
        wr_en = 1'b1;
        if (shift_more) begin
          rd_addr = AW'(idx_ext + EW'(2));
          idx_nxt = AW'(idx_ext + EW'(1));
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      krt_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krt_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    key_r    <= key_nxt;
    qty_r    <= qty_nxt;
    price_r  <= price_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    fq_r     <= fq_nxt;
    fp_r     <= fp_nxt;
  end

  assign out_ch.status            = status_r;
  assign out_ch.found_quantity    = fq_r;
  assign out_ch.found_price_cents = fp_r;
  assign out_ch.record_count      = 8'(count_r);

endmodule

// ===== test/tb_keyed_record_table.sv =====
// Testbench for keyed_record_table.
//
// The sender side presents requests from a queue that the main initial block
// fills before reset is released. A shadow copy of the record table, kept in
// this module, works out the result of every request at the clock edge where
// the block accepts it. The scoreboard then compares each result item that
// leaves the block with the oldest pending prediction.
module tb_keyed_record_table;
  import krt_pkg::*;

  localparam int TABLE_DEPTH = 128;

  // The worst request compares and moves at most depth entries in all. Add the
  // longest sender gap and receiver stall, then leave a wide margin.
  localparam int WORST_ITEM_CYCLES = TABLE_DEPTH + 2 + 18 + 18 + 4;
  localparam int CYCLE_LIMIT = 700000;
  localparam int KEY_POOL_SIZE = 16;

  // One request waiting to be presented. The gap is counted in idle cycles
  // before the request goes out. With hold_for_drain set, the sender first
  // waits until every predicted result has come back.
  typedef struct {
    action_t     act;
    logic [31:0] key;
    logic [31:0] qty;
    logic [31:0] price;
    int unsigned gap;
    bit          hold_for_drain;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] qty;
    logic [31:0] price;
    logic [7:0]  count;
  } table_reply_t;

  logic clk;
  logic rst_n;

  krt_in_if  in_ch ();
  krt_out_if out_ch ();

  keyed_record_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the record table.
  logic [31:0] shadow_key   [TABLE_DEPTH];
  logic [31:0] shadow_qty   [TABLE_DEPTH];
  logic [31:0] shadow_price [TABLE_DEPTH];
  int          shadow_count = 0;

  request_t     pending_requests [$];
  table_reply_t expected_replies [$];

  // The counters of accepted items are owned by the scoreboard, which runs
  // on the rising edge. The driver and the result sink read them on the
  // falling edge, so no read races with an update.
  int unsigned items_offered  = 0;
  int unsigned items_taken    = 0;
  int unsigned results_taken  = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  int unsigned send_wait   = 0;
  bit          gap_loaded  = 1'b0;
  int unsigned send_calm   = 0;
  int unsigned sink_pause  = 0;
  int unsigned sink_calm   = 0;

  logic [31:0] key_pool [KEY_POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the reply to one request and applies it to the shadow table.
  // Only entries below the record count are ever read.
  function automatic table_reply_t apply_request(action_t act, logic [31:0] key,
                                                 logic [31:0] qty, logic [31:0] price);
    table_reply_t reply;
    int           hit;
    int           j;
    reply.status = STAT_DONE;
    reply.qty    = '0;
    reply.price  = '0;
    hit = -1;
    if (act == ACT_ADD) begin
      if (shadow_count >= TABLE_DEPTH) begin
        reply.status = STAT_FULL;
      end else begin
        shadow_key[shadow_count]   = key;
        shadow_qty[shadow_count]   = qty;
        shadow_price[shadow_count] = price;
        shadow_count++;
      end
    end else begin
      // The earliest record with the key wins, so duplicates further down
      // the table stay hidden until it goes away.
      for (j = 0; j < shadow_count; j++) begin
        if (hit < 0 && shadow_key[j] == key) begin
          hit = j;
        end
      end
      if (hit < 0) begin
        reply.status = STAT_MISSING;
      end else if (act == ACT_SEARCH) begin
        reply.qty   = shadow_qty[hit];
        reply.price = shadow_price[hit];
      end else if (act == ACT_UPDATE) begin
        shadow_qty[hit]   = qty;
        shadow_price[hit] = price;
      end else begin
        // A delete closes the hole, keeping the order of later records.
        for (j = hit; j < shadow_count - 1; j++) begin
          shadow_key[j]   = shadow_key[j + 1];
          shadow_qty[j]   = shadow_qty[j + 1];
          shadow_price[j] = shadow_price[j + 1];
        end
        shadow_count--;
      end
    end
    reply.count = shadow_count[7:0];
    return reply;
  endfunction

  // Idle time for one item: none during a calm stretch, else a random pause.
  function automatic int unsigned draw_pause(bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Keys come mostly from a small pool so that searches, updates and deletes
  // find matches and duplicates pile up; the rest are fully random.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 3) != 0) begin
      return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    end
    return $urandom;
  endfunction

  task automatic queue_request(action_t act, logic [31:0] key, logic [31:0] qty,
                               logic [31:0] price, bit hold);
    request_t req;
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 19) == 0) begin
      send_calm = $urandom_range(10, 40);
    end
    req.act            = act;
    req.key            = key;
    req.qty            = qty;
    req.price          = price;
    req.gap            = draw_pause(send_calm != 0);
    req.hold_for_drain = hold || ($urandom_range(0, 49) == 0);
    pending_requests.push_back(req);
  endtask

  // A run of random requests. Some runs lean on deletes so that a full
  // table drains again.
  task automatic queue_mixed_run(int len);
    int          n;
    int unsigned add_pct;
    int unsigned del_pct;
    int unsigned roll;
    action_t     act;
    if ($urandom_range(0, 2) == 0) begin
      add_pct = 15;
      del_pct = 45;
    end else begin
      add_pct = 35;
      del_pct = 20;
    end
    for (n = 0; n < len; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
        act = ACT_ADD;
      end else if (roll < add_pct + del_pct) begin
        act = ACT_DELETE;
      end else if (roll < add_pct + del_pct + 25) begin
        act = ACT_SEARCH;
      end else begin
        act = ACT_UPDATE;
      end
      queue_request(act, pick_key(), $urandom, $urandom, 1'b0);
    end
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Driver. A new item is presented only once the one on the bus has been
  // taken, so valid is assigned once per falling edge and never toggles
  // within a step.
  always @(negedge clk) begin : request_driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && items_taken != items_offered)) begin
      if (pending_requests.size() != 0 && !gap_loaded) begin
        send_wait  = pending_requests[0].gap;
        gap_loaded = 1'b1;
      end
      if (pending_requests.size() == 0 || send_wait != 0 ||
          (pending_requests[0].hold_for_drain &&
           (expected_replies.size() != 0 || items_taken != items_offered))) begin
        if (send_wait != 0) begin
          send_wait--;
        end
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid           <= 1'b1;
        in_ch.action          <= pending_requests[0].act;
        in_ch.record_key      <= pending_requests[0].key;
        in_ch.new_quantity    <= pending_requests[0].qty;
        in_ch.new_price_cents <= pending_requests[0].price;
        void'(pending_requests.pop_front());
        items_offered++;
        gap_loaded = 1'b0;
      end
    end
  end

  // Result sink. After each accepted result it draws a fresh stall, with
  // occasional calm stretches where ready just stays high.
  always @(negedge clk) begin : result_sink
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        if (sink_calm > 0) begin
          sink_calm--;
        end else if ($urandom_range(0, 19) == 0) begin
          sink_calm = $urandom_range(10, 40);
        end
        sink_pause = draw_pause(sink_calm != 0);
      end
      if (sink_pause != 0) begin
        sink_pause--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Scoreboard. Results are checked before the request of the same edge is
  // predicted, which keeps the queue order correct.
  always @(posedge clk) begin : scoreboard
    table_reply_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_taken++;
        if (expected_replies.size() == 0) begin
          $display("%0t: result item with nothing expected, status %h count %h", $time,
                   out_ch.status, out_ch.record_count);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", {30'b0, want.status}, {30'b0, out_ch.status});
          check_field("found_quantity", want.qty, out_ch.found_quantity);
          check_field("found_price_cents", want.price, out_ch.found_price_cents);
          check_field("record_count", {24'b0, want.count}, {24'b0, out_ch.record_count});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        items_taken++;
        expected_replies.push_back(apply_request(action_t'(in_ch.action), in_ch.record_key,
                                                 in_ch.new_quantity, in_ch.new_price_cents));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : main
    int n;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_ADD;
    in_ch.record_key      = '0;
    in_ch.new_quantity    = '0;
    in_ch.new_price_cents = '0;
    out_ch.ready          = 1'b0;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (n = 4; n < KEY_POOL_SIZE; n++) begin
      key_pool[n] = $urandom;
    end

    // Directed part. An empty table misses on every lookup.
    queue_request(ACT_SEARCH, 32'h0, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_UPDATE, 32'h0, 32'h1234, 32'h5678, 1'b0);
    queue_request(ACT_DELETE, 32'h0, 32'h0, 32'h0, 1'b0);
    // Extremes of every field.
    queue_request(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0);
    queue_request(ACT_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    queue_request(ACT_ADD, 32'h0, 32'h0, 32'h1, 1'b0);
    // Duplicate keys: only the earliest record is seen until it is deleted.
    queue_request(ACT_ADD, 32'hffff_ffff, 32'h1, 32'd100, 1'b0);
    queue_request(ACT_ADD, 32'hffff_ffff, 32'h2, 32'd200, 1'b0);
    queue_request(ACT_SEARCH, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_UPDATE, 32'hffff_ffff, 32'hffff_fffb, 32'd12345, 1'b0);
    queue_request(ACT_SEARCH, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_DELETE, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_SEARCH, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_SEARCH, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_SEARCH, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
    // Deleting the first record moves every later one down.
    queue_request(ACT_DELETE, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_SEARCH, 32'd12345, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_UPDATE, 32'h7fff_ffff, 32'h5555_aaaa, 32'haaaa_5555, 1'b0);
    queue_request(ACT_SEARCH, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_DELETE, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
    // Delete the last record, then the only one left.
    queue_request(ACT_DELETE, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_DELETE, 32'h0, 32'h0, 32'h0, 1'b0);
    queue_request(ACT_SEARCH, 32'h0, 32'h0, 32'h0, 1'b0);

    // Random part, first with the sender waiting for the table to settle.
    queue_request(ACT_ADD, pick_key(), $urandom, $urandom, 1'b1);
    while (pending_requests.size() < 200) begin
      queue_mixed_run($urandom_range(15, 40));
    end

    // Fill the table past its depth so that adds report a full table, then
    // look up and delete in the full table, where a delete may shift almost
    // every record.
    queue_request(ACT_ADD, pick_key(), $urandom, $urandom, 1'b1);
    for (n = 0; n < TABLE_DEPTH + 8; n++) begin
      queue_request(ACT_ADD, pick_key(), $urandom, $urandom, 1'b0);
    end
    for (n = 0; n < 6; n++) begin
      queue_request(ACT_SEARCH, pick_key(), $urandom, $urandom, 1'b0);
    end
    for (n = 0; n < 4; n++) begin
      queue_request(ACT_DELETE, pick_key(), $urandom, $urandom, 1'b0);
    end
    while (pending_requests.size() < 500) begin
      queue_mixed_run($urandom_range(15, 40));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every item has gone in and every result has come out, then
    // give the block time to show any stray result.
    while (pending_requests.size() != 0 || items_taken != items_offered ||
           expected_replies.size() != 0) begin
      @(negedge clk);
    end
    repeat (WORST_ITEM_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/krt_pkg.sv
rtl/krt_if.sv
rtl/krt_store.sv
rtl/keyed_record_table.sv
test/tb_keyed_record_table.sv
